FILE: rtl/rpi_pkg.sv
`timescale 1ns / 1ps

package rpi_pkg;

    localparam int COORD_FRAC_BITS = 15;
    localparam int DIST_FRAC_BITS  = 16;
    localparam int COMP_W          = 21;
    localparam int VEC_W           = 3 * COMP_W;
    localparam int RADIUS_W        = 20;
    localparam int THRESH_W        = 30;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 30'd10737;

    // Threshold is in units of 2^-30, dot products in units of 2^-2F.
    localparam int THR_SHIFT  = 30 - 2 * COORD_FRAC_BITS;
    // Sphere root is in units of 2^-2F; the distance keeps DIST_FRAC_BITS.
    localparam int DIST_SHIFT = 2 * COORD_FRAC_BITS - DIST_FRAC_BITS;
    // The plane quotient is resolved below 2^QUOT_BITS; above that it saturates.
    localparam int QUOT_BITS  = 33;
    localparam int BIG_SHIFT  = QUOT_BITS - DIST_FRAC_BITS;

    localparam int B_W        = 44;   // (o-c).d, signed
    localparam int K_W        = 46;   // |o-c|^2 - r^2, signed
    localparam int BM_W       = 43;   // |b|
    localparam int BB_W       = 86;   // b^2
    localparam int KS_W       = 76;   // k scaled to units of 2^-4F
    localparam int ND_W       = 43;   // n.d, signed
    localparam int NP_W       = 44;   // n.(p-o), signed
    localparam int DEN_W      = 42;   // |n.d|
    localparam int NUM_W      = 43;   // |n.(p-o)|
    localparam int REM_W      = 88;   // remainder width of the shared step unit
    localparam int ROOT_STEPS = 44;   // one result bit per step
    localparam int ROOT_W     = 44;
    localparam int TS_W       = 33;

    typedef struct packed {
        logic                mode;
        logic [VEC_W-1:0]    ray_origin;
        logic [VEC_W-1:0]    ray_direction;
        logic [VEC_W-1:0]    prim_center;
        logic [VEC_W-1:0]    prim_normal;
        logic [RADIUS_W-1:0] prim_radius;
    } t_rpi_in;

    typedef struct packed {
        logic               no_root;
        logic signed [31:0] distance;
        logic               saturated;
    } t_rpi_out;

    // State carried through the square root / division steps.
    typedef struct packed {
        logic                  valid;
        logic                  mode;
        logic                  kill;
        logic                  big;
        logic                  neg;
        logic signed [B_W-1:0] b;
        logic [REM_W-1:0]      x;
        logic [REM_W-1:0]      res;
        logic [DEN_W-1:0]      den;
    } t_rpi_iter;

    function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] v,
                                                      input int idx);
        return v[idx*COMP_W +: COMP_W];
    endfunction

endpackage

FILE: rtl/rpi_front.sv
`timescale 1ns / 1ps

module rpi_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  rpi_pkg::t_rpi_in                 i_data,
    input  logic [rpi_pkg::THRESH_W-1:0]     i_thresh,
    output rpi_pkg::t_rpi_iter               o_iter
);

    localparam int C = rpi_pkg::COMP_W;
    localparam int NUM_EXT_W = rpi_pkg::DEN_W + rpi_pkg::BIG_SHIFT + 1;

    logic [6:1] r_v;

    // Stage 1: component differences.
    logic                     r_s1_mode;
    logic signed [C:0]        r_s1_dx  [3];
    logic signed [C:0]        r_s1_pmo [3];
    logic signed [C-1:0]      r_s1_d   [3];
    logic signed [C-1:0]      r_s1_n   [3];
    logic [rpi_pkg::RADIUS_W-1:0] r_s1_r;

    // Stage 2: products.
    logic                     r_s2_mode;
    logic signed [42:0]       r_s2_bd [3];
    logic signed [42:0]       r_s2_kk [3];
    logic signed [41:0]       r_s2_nd [3];
    logic signed [42:0]       r_s2_np [3];
    logic [39:0]              r_s2_rr;

    // Stage 3: dot products.
    logic                              r_s3_mode;
    logic signed [rpi_pkg::B_W-1:0]    r_s3_b;
    logic signed [rpi_pkg::K_W-1:0]    r_s3_k;
    logic signed [rpi_pkg::ND_W-1:0]   r_s3_nd;
    logic signed [rpi_pkg::NP_W-1:0]   r_s3_np;

    // Stage 4: magnitudes.
    logic                              r_s4_mode;
    logic signed [rpi_pkg::B_W-1:0]    r_s4_b;
    logic [rpi_pkg::BM_W-1:0]          r_s4_bm;
    logic signed [rpi_pkg::KS_W-1:0]   r_s4_ks;
    logic [rpi_pkg::DEN_W-1:0]         r_s4_den;
    logic [rpi_pkg::NUM_W-1:0]         r_s4_num;
    logic                              r_s4_neg;

    // Stage 5: partial products of b^2, plane checks.
    logic                              r_s5_mode;
    logic signed [rpi_pkg::B_W-1:0]    r_s5_b;
    logic [41:0]                       r_s5_hh;
    logic [42:0]                       r_s5_hl;
    logic [43:0]                       r_s5_ll;
    logic signed [rpi_pkg::KS_W-1:0]   r_s5_ks;
    logic [rpi_pkg::DEN_W-1:0]         r_s5_den;
    logic [rpi_pkg::NUM_W-1:0]         r_s5_num;
    logic                              r_s5_neg;
    logic                              r_s5_flat;
    logic                              r_s5_big;

    // Stage 6: b^2.
    logic                              r_s6_mode;
    logic signed [rpi_pkg::B_W-1:0]    r_s6_b;
    logic [rpi_pkg::BB_W-1:0]          r_s6_bb;
    logic signed [rpi_pkg::KS_W-1:0]   r_s6_ks;
    logic [rpi_pkg::DEN_W-1:0]         r_s6_den;
    logic [rpi_pkg::NUM_W-1:0]         r_s6_num;
    logic                              r_s6_neg;
    logic                              r_s6_flat;
    logic                              r_s6_big;

    // Stage 7: discriminant and step-unit operands.
    rpi_pkg::t_rpi_iter                r_s7;

    logic signed [rpi_pkg::REM_W-1:0]  n_disc;
    logic                              n_miss;
    logic [rpi_pkg::DEN_W+rpi_pkg::THR_SHIFT:0] n_den_scaled;
    logic [rpi_pkg::DEN_W+rpi_pkg::THR_SHIFT:0] n_thr_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_s7     <= '0;
        end else if (i_en) begin
            r_v        <= {r_v[5:1], i_valid};
            r_s7.valid <= r_v[6];
            r_s7.mode  <= r_s6_mode;
            r_s7.kill  <= r_s6_mode ? r_s6_flat : n_miss;
            r_s7.big   <= r_s6_big;
            r_s7.neg   <= r_s6_neg;
            r_s7.b     <= r_s6_b;
            r_s7.x     <= r_s6_mode
                        ? (rpi_pkg::REM_W'(r_s6_num) << rpi_pkg::DIST_FRAC_BITS)
                        : n_disc;
            r_s7.res   <= '0;
            r_s7.den   <= r_s6_den;
        end
    end

    always_comb begin
        n_den_scaled = (rpi_pkg::DEN_W+rpi_pkg::THR_SHIFT+1)'(r_s4_den) << rpi_pkg::THR_SHIFT;
        n_thr_ext    = (rpi_pkg::DEN_W+rpi_pkg::THR_SHIFT+1)'(i_thresh);
        n_disc = $signed({2'b00, r_s6_bb}) - rpi_pkg::REM_W'(r_s6_ks);
        n_miss = n_disc[rpi_pkg::REM_W-1] || (n_disc == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_mode <= i_data.mode;
            r_s1_r    <= i_data.prim_radius;
            for (int i = 0; i < 3; i++) begin
                r_s1_dx[i]  <= (C+1)'(rpi_pkg::comp(i_data.ray_origin, i))
                             - (C+1)'(rpi_pkg::comp(i_data.prim_center, i));
                r_s1_pmo[i] <= (C+1)'(rpi_pkg::comp(i_data.prim_center, i))
                             - (C+1)'(rpi_pkg::comp(i_data.ray_origin, i));
                r_s1_d[i]   <= rpi_pkg::comp(i_data.ray_direction, i);
                r_s1_n[i]   <= rpi_pkg::comp(i_data.prim_normal, i);
            end

            r_s2_mode <= r_s1_mode;
            r_s2_rr   <= r_s1_r * r_s1_r;
            for (int i = 0; i < 3; i++) begin
                r_s2_bd[i] <= r_s1_dx[i] * r_s1_d[i];
                r_s2_kk[i] <= r_s1_dx[i] * r_s1_dx[i];
                r_s2_nd[i] <= r_s1_n[i] * r_s1_d[i];
                r_s2_np[i] <= r_s1_n[i] * r_s1_pmo[i];
            end

            r_s3_mode <= r_s2_mode;
            r_s3_b  <= rpi_pkg::B_W'(r_s2_bd[0]) + rpi_pkg::B_W'(r_s2_bd[1])
                     + rpi_pkg::B_W'(r_s2_bd[2]);
            r_s3_k  <= rpi_pkg::K_W'(r_s2_kk[0]) + rpi_pkg::K_W'(r_s2_kk[1])
                     + rpi_pkg::K_W'(r_s2_kk[2]) - $signed({6'b0, r_s2_rr});
            r_s3_nd <= rpi_pkg::ND_W'(r_s2_nd[0]) + rpi_pkg::ND_W'(r_s2_nd[1])
                     + rpi_pkg::ND_W'(r_s2_nd[2]);
            r_s3_np <= rpi_pkg::NP_W'(r_s2_np[0]) + rpi_pkg::NP_W'(r_s2_np[1])
                     + rpi_pkg::NP_W'(r_s2_np[2]);

            r_s4_mode <= r_s3_mode;
            r_s4_b    <= r_s3_b;
            r_s4_bm   <= rpi_pkg::BM_W'(r_s3_b[rpi_pkg::B_W-1] ? -r_s3_b : r_s3_b);
            r_s4_ks   <= rpi_pkg::KS_W'(r_s3_k) <<< (2 * rpi_pkg::COORD_FRAC_BITS);
            r_s4_den  <= rpi_pkg::DEN_W'(r_s3_nd[rpi_pkg::ND_W-1] ? -r_s3_nd : r_s3_nd);
            r_s4_num  <= rpi_pkg::NUM_W'(r_s3_np[rpi_pkg::NP_W-1] ? -r_s3_np : r_s3_np);
            r_s4_neg  <= r_s3_nd[rpi_pkg::ND_W-1] ^ r_s3_np[rpi_pkg::NP_W-1];

            r_s5_mode <= r_s4_mode;
            r_s5_b    <= r_s4_b;
            r_s5_hh   <= r_s4_bm[42:22] * r_s4_bm[42:22];
            r_s5_hl   <= r_s4_bm[42:22] * r_s4_bm[21:0];
            r_s5_ll   <= r_s4_bm[21:0] * r_s4_bm[21:0];
            r_s5_ks   <= r_s4_ks;
            r_s5_den  <= r_s4_den;
            r_s5_num  <= r_s4_num;
            r_s5_neg  <= r_s4_neg;
            // A zero n.d never hits, even with a zero threshold.
            r_s5_flat <= (r_s4_den == '0) || (n_den_scaled < n_thr_ext);
            r_s5_big  <= (NUM_EXT_W)'(r_s4_num) >= ((NUM_EXT_W)'(r_s4_den) << rpi_pkg::BIG_SHIFT);

            r_s6_mode <= r_s5_mode;
            r_s6_b    <= r_s5_b;
            r_s6_bb   <= (rpi_pkg::BB_W'(r_s5_hh) << 44) + (rpi_pkg::BB_W'(r_s5_hl) << 23)
                       + rpi_pkg::BB_W'(r_s5_ll);
            r_s6_ks   <= r_s5_ks;
            r_s6_den  <= r_s5_den;
            r_s6_num  <= r_s5_num;
            r_s6_neg  <= r_s5_neg;
            r_s6_flat <= r_s5_flat;
            r_s6_big  <= r_s5_big;
        end
    end

    assign o_iter = r_s7;

endmodule

FILE: rtl/rpi_step.sv
`timescale 1ns / 1ps

// One bit of the floor square root (sphere) or of the quotient (plane).
module rpi_step #(
    parameter int STEP = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  rpi_pkg::t_rpi_iter i_stage,
    output rpi_pkg::t_rpi_iter o_stage
);

    localparam int ROOT_POS = rpi_pkg::REM_W - 2 - 2 * STEP;
    localparam int QUOT_POS = rpi_pkg::ROOT_STEPS - 1 - STEP;

    logic [rpi_pkg::REM_W-1:0] n_root_bit;
    logic [rpi_pkg::REM_W-1:0] n_trial;
    logic                      n_ge;
    rpi_pkg::t_rpi_iter        n_stage;
    rpi_pkg::t_rpi_iter        r_stage;

    always_comb begin
        n_root_bit = rpi_pkg::REM_W'(1) << ROOT_POS;
        n_trial    = i_stage.mode
                   ? (rpi_pkg::REM_W'(i_stage.den) << QUOT_POS)
                   : (i_stage.res + n_root_bit);
        n_ge       = i_stage.x >= n_trial;
        n_stage    = i_stage;
        if (n_ge) begin
            n_stage.x = i_stage.x - n_trial;
        end
        if (i_stage.mode) begin
            n_stage.res = i_stage.res | (rpi_pkg::REM_W'(n_ge) << QUOT_POS);
        end else begin
            n_stage.res = (i_stage.res >> 1) | (n_ge ? n_root_bit : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: rtl/rpi_back.sv
`timescale 1ns / 1ps

module rpi_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  rpi_pkg::t_rpi_iter i_stage,
    output logic               o_valid,
    output rpi_pkg::t_rpi_out  o_data
);

    localparam int T2_W = rpi_pkg::B_W + 3;

    logic                               r_b1_v;
    logic                               r_b1_mode;
    logic                               r_b1_kill;
    logic                               r_b1_big;
    logic                               r_b1_neg;
    logic signed [rpi_pkg::TS_W-1:0]    r_b1_ts;
    logic [rpi_pkg::QUOT_BITS-1:0]      r_b1_q;

    logic signed [T2_W-1:0]             n_t2;
    logic signed [T2_W-1:0]             n_t2_sh;

    logic                               r_b2_v;
    rpi_pkg::t_rpi_out                  r_b2;
    rpi_pkg::t_rpi_out                  n_out;
    logic [rpi_pkg::QUOT_BITS-1:0]      n_qneg;

    always_comb begin
        n_t2 = -T2_W'(i_stage.b)
             - $signed({3'b000, i_stage.res[rpi_pkg::ROOT_W-1:0]});
        // Arithmetic shift floors toward minus infinity.
        n_t2_sh = n_t2 >>> rpi_pkg::DIST_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
        end else if (i_en) begin
            r_b1_v <= i_stage.valid;
            r_b2_v <= r_b1_v;
        end
    end

    always_comb begin
        n_qneg = -r_b1_q;
        n_out  = '0;
        if (r_b1_kill) begin
            n_out.no_root = 1'b1;
        end else if (!r_b1_mode) begin
            if (!r_b1_ts[rpi_pkg::TS_W-1] && r_b1_ts[31]) begin
                n_out.saturated = 1'b1;
                n_out.distance  = 32'sh7FFF_FFFF;
            end else if (r_b1_ts[rpi_pkg::TS_W-1] && !r_b1_ts[31]) begin
                n_out.saturated = 1'b1;
                n_out.distance  = 32'sh8000_0000;
            end else begin
                n_out.distance  = r_b1_ts[31:0];
            end
        end else if (!r_b1_neg) begin
            if (r_b1_big || r_b1_q[32] || r_b1_q[31]) begin
                n_out.saturated = 1'b1;
                n_out.distance  = 32'sh7FFF_FFFF;
            end else begin
                n_out.distance  = r_b1_q[31:0];
            end
        end else begin
            if (r_b1_big || r_b1_q > 33'h0_8000_0000) begin
                n_out.saturated = 1'b1;
                n_out.distance  = 32'sh8000_0000;
            end else begin
                n_out.distance  = n_qneg[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1_mode <= i_stage.mode;
            r_b1_kill <= i_stage.kill;
            r_b1_big  <= i_stage.big;
            r_b1_neg  <= i_stage.neg;
            r_b1_ts   <= n_t2_sh[rpi_pkg::TS_W-1:0];
            r_b1_q    <= i_stage.res[rpi_pkg::QUOT_BITS-1:0];
            r_b2      <= n_out;
        end
    end

    assign o_valid = r_b2_v;
    assign o_data  = r_b2;

endmodule

FILE: rtl/ray_primitive_intersection.sv
`timescale 1ns / 1ps

// Ray / sphere and ray / plane intersection, one test per item.
// Input channel: i_in_valid / o_in_ready with the ray and primitive in i_in_data;
// a transfer happens on a clock edge where both are high. Output channel:
// o_out_valid / i_out_ready with no_root, distance and saturated in o_out_data.
// The threshold register is written by i_cfg_we / i_cfg_data; write
// it only while no test is in flight.
// Throughput is one test per cycle while the output does not stall. Each test
// passes seven front stages (differences, products, sums, magnitudes, b^2
// partial products, b^2, discriminant), 44 stages of the shared
// compare-subtract step that forms the square root or the quotient one bit at
// a time, two stages of rounding and clamping, and the output register.
// When the receiver stalls, one more result is caught in a skid register and
// then the whole pipeline holds; nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline and sets the threshold to
// its default.
module ray_primitive_intersection (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rpi_pkg::t_rpi_in                 i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rpi_pkg::t_rpi_out                o_out_data,
    input  logic                             i_cfg_we,
    input  logic [rpi_pkg::THRESH_W-1:0]     i_cfg_data
);

    logic [rpi_pkg::THRESH_W-1:0] r_thresh;
    logic                         w_en;
    rpi_pkg::t_rpi_iter           w_iter [rpi_pkg::ROOT_STEPS+1];
    logic                         w_pipe_v;
    rpi_pkg::t_rpi_out            w_pipe_d;
    logic                         r_out_v;
    rpi_pkg::t_rpi_out            r_out_d;
    logic                         r_skid_v;
    rpi_pkg::t_rpi_out            r_skid_d;

    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= rpi_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_data;
        end
    end

    rpi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_data   (i_in_data),
        .i_thresh (r_thresh),
        .o_iter   (w_iter[0])
    );

    for (genvar g = 0; g < rpi_pkg::ROOT_STEPS; g++) begin : g_step
        rpi_step #(.STEP(g)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_iter[g]),
            .o_stage (w_iter[g+1])
        );
    end

    rpi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_stage (w_iter[rpi_pkg::ROOT_STEPS]),
        .o_valid (w_pipe_v),
        .o_data  (w_pipe_d)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_out_ready) begin
                r_out_d  <= r_skid_d;
                r_skid_v <= 1'b0;
            end
        end else if (w_pipe_v) begin
            if (!r_out_v || i_out_ready) begin
                r_out_d <= w_pipe_d;
                r_out_v <= 1'b1;
            end else begin
                r_skid_d <= w_pipe_d;
                r_skid_v <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out_d;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a result while the output is empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |=> !r_skid_v)
        else $error("skid register loaded without a stalled output");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.no_root)
            |-> (o_out_data.distance == '0 && !o_out_data.saturated))
        else $error("no_root result carries a distance or saturation flag");

    a_thresh_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_thresh == rpi_pkg::THRESH_RESET)
        else $error("threshold not restored by reset");
`endif

endmodule
